// ===== hdl/spmd_pkg.sv =====
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared codes, types and the default-action decode for the signal pending
// mask dispatcher.
// ----------------------------------------------------------------------------
package spmd_pkg;

   // field widths
   localparam int SIG_W = 6;
   localparam int REQ_W = 3;
   localparam int ACT_W = 2;
   localparam int OC_W  = 3;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_REGISTER = 3'd0,
      REQ_MASK     = 3'd1,
      REQ_UNMASK   = 3'd2,
      REQ_SEND     = 3'd3,
      REQ_DELIVER  = 3'd4
   } req_code_type;

   // action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_DEFAULT = 2'd0,
      ACT_IGNORE  = 2'd1,
      ACT_USER    = 2'd2
   } action_type;

   // outcome codes
   typedef enum logic [OC_W-1:0] {
      OC_DONE    = 3'd0,
      OC_QUEUED  = 3'd1,
      OC_IGNORED = 3'd2,
      OC_DFL_IGN = 3'd3,
      OC_TERM    = 3'd4,
      OC_STOP    = 3'd5,
      OC_USER    = 3'd6,
      OC_REJECT  = 3'd7
   } outcome_type;

   // signal numbers with a fixed default meaning
   localparam logic [SIG_W-1:0] SIG_ABRT = 6'd6;
   localparam logic [SIG_W-1:0] SIG_KILL = 6'd9;
   localparam logic [SIG_W-1:0] SIG_SEGV = 6'd11;
   localparam logic [SIG_W-1:0] SIG_TERM = 6'd15;
   localparam logic [SIG_W-1:0] SIG_CHLD = 6'd17;
   localparam logic [SIG_W-1:0] SIG_CONT = 6'd18;
   localparam logic [SIG_W-1:0] SIG_STOP = 6'd19;
   localparam logic [SIG_W-1:0] SIG_TSTP = 6'd20;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_step;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_deliver;
      logic none_pending;
      logic scan_done;
   } sts_type;

   // outcome of an unblocked signal according to its action
   function automatic logic [OC_W-1:0] dispatch(input logic [SIG_W-1:0] sig,
                                                input logic [ACT_W-1:0] act);
      logic [OC_W-1:0] oc;
      if (act == ACT_IGNORE) begin
         oc = OC_IGNORED;
      end else if (act == ACT_DEFAULT) begin
         case (sig) inside
            SIG_CHLD, SIG_CONT: oc = OC_DFL_IGN;
            SIG_STOP, SIG_TSTP: oc = OC_STOP;
            SIG_KILL, SIG_TERM, SIG_SEGV, SIG_ABRT: oc = OC_TERM;
            default: oc = OC_TERM;
         endcase
      end else begin
         oc = OC_USER;
      end
      return oc;
   endfunction

endpackage

// ===== hdl/spmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmd_ctrl
// Sequencer: takes a request, runs its evaluate cycle and, for deliver
// pending, walks the scan until the last deliverable signal is issued.
// ----------------------------------------------------------------------------
module spmd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spmd_pkg::sts_type sts,
   output spmd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.exec      = 1'b0;
      cmd.scan_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.is_deliver && !sts.none_pending) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   // an evaluate cycle always follows a capture
   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.capture))
      else $error("evaluate without a captured transaction");

   // a scan is entered only from a deliver request
   a_scan_from_deliver: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && !$past(cmd.scan_step)) |-> $past(cmd.exec && sts.is_deliver))
      else $error("scan started without a deliver request");
`endif

endmodule

// ===== hdl/spmd_dp.sv =====
// ----------------------------------------------------------------------------
// spmd_dp
// Datapath: request registers, pending and blocked masks, action table,
// deliver scan and the registered result outputs.
// ----------------------------------------------------------------------------
module spmd_dp #(
   parameter int NUM_SIGNALS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spmd_pkg::cmd_type             cmd,
   output spmd_pkg::sts_type             sts,
   input  logic [spmd_pkg::REQ_W-1:0]    req_type,
   input  logic [spmd_pkg::SIG_W-1:0]    req_signal_number,
   input  logic [spmd_pkg::ACT_W-1:0]    req_new_action,
   output logic                          rsp_valid,
   output logic [spmd_pkg::SIG_W-1:0]    rsp_signal_number_out,
   output logic [spmd_pkg::OC_W-1:0]     rsp_outcome,
   output logic [spmd_pkg::ACT_W-1:0]    rsp_old_action,
   output logic                          rsp_last
);

   localparam int IDX_W = $clog2(NUM_SIGNALS);
   localparam logic [spmd_pkg::SIG_W:0] NUM_SIG_LIM = (spmd_pkg::SIG_W+1)'(NUM_SIGNALS);

   // captured request
   logic [spmd_pkg::REQ_W-1:0] req_type_ff, req_type_in;
   logic [spmd_pkg::SIG_W-1:0] req_sig_ff, req_sig_in;
   logic [spmd_pkg::ACT_W-1:0] req_act_ff, req_act_in;

   // signal state
   logic [NUM_SIGNALS-1:0]     pending_ff, pending_in;
   logic [NUM_SIGNALS-1:0]     blocked_ff, blocked_in;
   logic [spmd_pkg::ACT_W-1:0] action_ff [NUM_SIGNALS];
   logic [spmd_pkg::ACT_W-1:0] action_in [NUM_SIGNALS];

   // deliver scan
   logic [NUM_SIGNALS-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;

   // result registers
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [spmd_pkg::SIG_W-1:0] rsp_sig_ff, rsp_sig_in;
   logic [spmd_pkg::OC_W-1:0]  rsp_oc_ff, rsp_oc_in;
   logic [spmd_pkg::ACT_W-1:0] rsp_old_ff, rsp_old_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       sig_ok;
   logic                       sig_fixed;
   logic [IDX_W-1:0]           tab_idx;
   logic [spmd_pkg::ACT_W-1:0] act_rd;
   logic [NUM_SIGNALS-1:0]     req_bit;
   logic [NUM_SIGNALS-1:0]     scan_bit;
   logic [NUM_SIGNALS-1:0]     deliverable;
   logic                       scan_rest;
   logic [spmd_pkg::SIG_W-1:0] scan_sig;

   // request decode and table read port
   always_comb begin
      sig_ok      = (req_sig_ff != '0) && ({1'b0, req_sig_ff} < NUM_SIG_LIM);
      sig_fixed   = (req_sig_ff == spmd_pkg::SIG_KILL) || (req_sig_ff == spmd_pkg::SIG_STOP);
      tab_idx     = cmd.scan_step ? idx_ff : req_sig_ff[IDX_W-1:0];
      act_rd      = action_ff[tab_idx];
      req_bit     = {{(NUM_SIGNALS-1){1'b0}}, 1'b1} << req_sig_ff[IDX_W-1:0];
      scan_bit    = {{(NUM_SIGNALS-1){1'b0}}, 1'b1} << idx_ff;
      deliverable = pending_ff & ~blocked_ff;
      scan_rest   = |(scan_ff & ~scan_bit);
      scan_sig    = spmd_pkg::SIG_W'(idx_ff);
   end

   // status to the sequencer
   always_comb begin
      sts.is_deliver   = (req_type_ff == spmd_pkg::REQ_DELIVER);
      sts.none_pending = (deliverable == '0);
      sts.scan_done    = scan_ff[idx_ff] && !scan_rest;
   end

   // request execution
   always_comb begin
      req_type_in  = req_type_ff;
      req_sig_in   = req_sig_ff;
      req_act_in   = req_act_ff;
      pending_in   = pending_ff;
      blocked_in   = blocked_ff;
      action_in    = action_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_sig_in   = req_sig_ff;
      rsp_oc_in    = spmd_pkg::OC_DONE;
      rsp_old_in   = spmd_pkg::ACT_DEFAULT;
      rsp_last_in  = 1'b1;

      // latch a new transaction
      if (cmd.capture) begin
         req_type_in = req_type;
         req_sig_in  = req_signal_number;
         req_act_in  = req_new_action;
      end

      // single evaluate cycle
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         case (req_type_ff)
            spmd_pkg::REQ_REGISTER: begin
               if (!sig_ok || sig_fixed || (req_act_ff > spmd_pkg::ACT_USER)) begin
                  rsp_oc_in = spmd_pkg::OC_REJECT;
               end else begin
                  rsp_old_in                          = act_rd;
                  action_in[req_sig_ff[IDX_W-1:0]] = req_act_ff;
               end
            end
            spmd_pkg::REQ_MASK: begin
               if (!sig_ok || sig_fixed) begin
                  rsp_oc_in = spmd_pkg::OC_REJECT;
               end else begin
                  blocked_in = blocked_ff | req_bit;
               end
            end
            spmd_pkg::REQ_UNMASK: begin
               if (!sig_ok) begin
                  rsp_oc_in = spmd_pkg::OC_REJECT;
               end else begin
                  blocked_in = blocked_ff & ~req_bit;
               end
            end
            spmd_pkg::REQ_SEND: begin
               if (!sig_ok) begin
                  rsp_oc_in = spmd_pkg::OC_REJECT;
               end else if (|(blocked_ff & req_bit)) begin
                  pending_in = pending_ff | req_bit;
                  rsp_oc_in  = spmd_pkg::OC_QUEUED;
               end else begin
                  rsp_oc_in = spmd_pkg::dispatch(req_sig_ff, act_rd);
               end
            end
            spmd_pkg::REQ_DELIVER: begin
               scan_in = deliverable;
               idx_in  = IDX_W'(1);
               if (deliverable == '0) begin
                  rsp_sig_in = '0;
               end else begin
                  rsp_valid_in = 1'b0;
               end
            end
            default: rsp_oc_in = spmd_pkg::OC_REJECT;
         endcase
      end

      // one signal number per cycle during deliver
      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (scan_ff[idx_ff]) begin
            rsp_valid_in = 1'b1;
            rsp_sig_in   = scan_sig;
            rsp_oc_in    = spmd_pkg::dispatch(scan_sig, act_rd);
            rsp_last_in  = !scan_rest;
            pending_in   = pending_ff & ~scan_bit;
            scan_in      = scan_ff & ~scan_bit;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         blocked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SIGNALS; i++) begin
            action_ff[i] <= spmd_pkg::ACT_DEFAULT;
         end
      end else begin
         pending_ff   <= pending_in;
         blocked_ff   <= blocked_in;
         rsp_valid_ff <= rsp_valid_in;
         action_ff    <= action_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      req_sig_ff  <= req_sig_in;
      req_act_ff  <= req_act_in;
      scan_ff     <= scan_in;
      idx_ff      <= idx_in;
      rsp_sig_ff  <= rsp_sig_in;
      rsp_oc_ff   <= rsp_oc_in;
      rsp_old_ff  <= rsp_old_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_signal_number_out = rsp_sig_ff;
   assign rsp_outcome           = rsp_oc_ff;
   assign rsp_old_action        = rsp_old_ff;
   assign rsp_last              = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // signal zero can never become pending
   a_no_pending_zero: assert property (@(posedge clock) disable iff (reset)
      !pending_ff[0])
      else $error("pending bit for signal zero set");

   // every bit still to be scanned is still pending
   a_scan_in_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> ((scan_ff & ~pending_ff) == '0))
      else $error("scan bit without pending bit");
`endif

endmodule

// ===== hdl/signal_pending_mask_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatcher_core
// Pending/blocked mask signal dispatcher with per-signal actions.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Register, mask,
// unmask and send requests run the evaluate cycle, then the single result
// is on the rsp_ ports for one cycle with rsp_valid high, during which busy
// is already low and the next request can be taken. Deliver pending scans
// the signal numbers one per clock, from 1 up to the highest deliverable
// signal h, and issues one result for each deliverable signal; with nothing
// deliverable it gives a single done result. The receiver has no way to
// stall, so every strobed result must be taken on the cycle it is shown.
module signal_pending_mask_dispatcher_core #(
   parameter int NUM_SIGNALS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [spmd_pkg::REQ_W-1:0] req_type,
   input  logic [spmd_pkg::SIG_W-1:0] req_signal_number,
   input  logic [spmd_pkg::ACT_W-1:0] req_new_action,
   output logic                       rsp_valid,
   output logic [spmd_pkg::SIG_W-1:0] rsp_signal_number_out,
   output logic [spmd_pkg::OC_W-1:0]  rsp_outcome,
   output logic [spmd_pkg::ACT_W-1:0] rsp_old_action,
   output logic                       rsp_last
);

   spmd_pkg::cmd_type cmd;
   spmd_pkg::sts_type sts;

   // sequencer
   spmd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath
   spmd_dp #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_type              (req_type),
      .req_signal_number     (req_signal_number),
      .req_new_action        (req_new_action),
      .rsp_valid             (rsp_valid),
      .rsp_signal_number_out (rsp_signal_number_out),
      .rsp_outcome           (rsp_outcome),
      .rsp_old_action        (rsp_old_action),
      .rsp_last              (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but block not busy");

   // a result only follows a busy cycle
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signal pending mask dispatcher. A directed table
// hits rejects, default actions, register/mask/send and delivery corners, then
// random request sequences (mask, send, re-register, unmask, deliver) and a
// flood of the upper signals run against a local predictor of masks and actions.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_SIGNALS  = 32;
   localparam int RANDOM_ITEMS = 50;
   localparam int FLOOD_FIRST  = 16;
   localparam int SETTLE       = 40;

   // request codes that the block must reject
   localparam logic [spmd_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [spmd_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
   // action code outside the legal set
   localparam logic [spmd_pkg::ACT_W-1:0] ACT_INVALID = 2'd3;

   typedef struct packed {
      logic [spmd_pkg::SIG_W-1:0] sig;
      spmd_pkg::outcome_type      outcome;
      logic [spmd_pkg::ACT_W-1:0] old_act;
      logic                       last;
   } sig_result_type;

   typedef struct packed {
      logic [spmd_pkg::REQ_W-1:0] req;
      logic [spmd_pkg::SIG_W-1:0] sig;
      logic [spmd_pkg::ACT_W-1:0] act;
      logic                       fixed;
      logic [spmd_pkg::SIG_W-1:0] esig;
      spmd_pkg::outcome_type      oc;
      logic [spmd_pkg::ACT_W-1:0] old_act;
   } plan_row_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [spmd_pkg::REQ_W-1:0] req_type;
   logic [spmd_pkg::SIG_W-1:0] req_signal_number;
   logic [spmd_pkg::ACT_W-1:0] req_new_action;
   logic                       rsp_valid;
   logic [spmd_pkg::SIG_W-1:0] rsp_signal_number_out;
   logic [spmd_pkg::OC_W-1:0]  rsp_outcome;
   logic [spmd_pkg::ACT_W-1:0] rsp_old_action;
   logic                       rsp_last;

   // predictor state
   logic [31:0]                model_pending;
   logic [31:0]                model_blocked;
   logic [spmd_pkg::ACT_W-1:0] model_action [0:31];

   sig_result_type outcomes_due [$];
   sig_result_type head_result;

   int mismatches;
   int requests_sent;
   int results_seen;
   int run_len;
   int longest_run;
   int burst_left;

   // directed table: fixed expectations only where obvious
   plan_row_type dispatch_plan [27] = '{
      '{spmd_pkg::REQ_SEND, 6'd0, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd0, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, 6'd63, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd63, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_MASK, 6'd32, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd32, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_REGISTER, spmd_pkg::SIG_KILL, spmd_pkg::ACT_USER, 1'b1,
        spmd_pkg::SIG_KILL, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_REGISTER, spmd_pkg::SIG_STOP, spmd_pkg::ACT_IGNORE, 1'b1,
        spmd_pkg::SIG_STOP, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_REGISTER, 6'd5, ACT_INVALID, 1'b1,
        6'd5, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_MASK, spmd_pkg::SIG_KILL, spmd_pkg::ACT_DEFAULT, 1'b1,
        spmd_pkg::SIG_KILL, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_MASK, spmd_pkg::SIG_STOP, spmd_pkg::ACT_DEFAULT, 1'b1,
        spmd_pkg::SIG_STOP, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{REQ_UNUSED_LO, 6'd3, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd3, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{REQ_UNUSED_HI, 6'd63, ACT_INVALID, 1'b1,
        6'd63, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_DELIVER, 6'd0, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd0, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, spmd_pkg::SIG_CHLD, spmd_pkg::ACT_DEFAULT, 1'b1,
        spmd_pkg::SIG_CHLD, spmd_pkg::OC_DFL_IGN, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, spmd_pkg::SIG_STOP, spmd_pkg::ACT_DEFAULT, 1'b1,
        spmd_pkg::SIG_STOP, spmd_pkg::OC_STOP, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, spmd_pkg::SIG_KILL, spmd_pkg::ACT_DEFAULT, 1'b1,
        spmd_pkg::SIG_KILL, spmd_pkg::OC_TERM, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, 6'd31, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd31, spmd_pkg::OC_TERM, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_REGISTER, 6'd31, spmd_pkg::ACT_USER, 1'b1,
        6'd31, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_REGISTER, 6'd31, spmd_pkg::ACT_IGNORE, 1'b1,
        6'd31, spmd_pkg::OC_DONE, spmd_pkg::ACT_USER},
      '{spmd_pkg::REQ_SEND, 6'd31, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd31, spmd_pkg::OC_IGNORED, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_MASK, 6'd1, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd1, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_MASK, 6'd31, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd31, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, 6'd1, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd1, spmd_pkg::OC_QUEUED, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_SEND, 6'd31, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd31, spmd_pkg::OC_QUEUED, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_UNMASK, 6'd1, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd1, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_DELIVER, 6'd0, spmd_pkg::ACT_DEFAULT, 1'b0,
        6'd0, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_UNMASK, 6'd63, spmd_pkg::ACT_DEFAULT, 1'b1,
        6'd63, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_UNMASK, 6'd31, spmd_pkg::ACT_DEFAULT, 1'b0,
        6'd0, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT},
      '{spmd_pkg::REQ_DELIVER, 6'd0, spmd_pkg::ACT_USER, 1'b0,
        6'd0, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT}
   };

   signal_pending_mask_dispatcher_core #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_signal_number     (req_signal_number),
      .req_new_action        (req_new_action),
      .rsp_valid             (rsp_valid),
      .rsp_signal_number_out (rsp_signal_number_out),
      .rsp_outcome           (rsp_outcome),
      .rsp_old_action        (rsp_old_action),
      .rsp_last              (rsp_last)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #2000000;
      $display("timeout with %0d results still awaited", outcomes_due.size());
      $display("Mismatches found");
      $finish;
   end

   // outcome of an unblocked signal by its action
   function automatic spmd_pkg::outcome_type resolve_outcome(
      input logic [spmd_pkg::SIG_W-1:0] sig,
      input logic [spmd_pkg::ACT_W-1:0] act);
      spmd_pkg::outcome_type oc;
      if (act == spmd_pkg::ACT_IGNORE) begin
         oc = spmd_pkg::OC_IGNORED;
      end else if (act == spmd_pkg::ACT_USER) begin
         oc = spmd_pkg::OC_USER;
      end else if (sig == spmd_pkg::SIG_CHLD || sig == spmd_pkg::SIG_CONT) begin
         oc = spmd_pkg::OC_DFL_IGN;
      end else if (sig == spmd_pkg::SIG_STOP || sig == spmd_pkg::SIG_TSTP) begin
         oc = spmd_pkg::OC_STOP;
      end else begin
         oc = spmd_pkg::OC_TERM;
      end
      return oc;
   endfunction

   // predictor: update state and queue the results of one transaction
   task automatic predict_dispatch(input logic [spmd_pkg::REQ_W-1:0] req,
                                   input logic [spmd_pkg::SIG_W-1:0] sig,
                                   input logic [spmd_pkg::ACT_W-1:0] act);
      sig_result_type res;
      logic [31:0]    ready;
      logic           in_range;
      logic           fixed_sig;
      int             count;
      in_range  = (sig >= 1) && (sig < NUM_SIGNALS);
      fixed_sig = (sig == spmd_pkg::SIG_KILL) || (sig == spmd_pkg::SIG_STOP);
      res       = '{sig, spmd_pkg::OC_REJECT, spmd_pkg::ACT_DEFAULT, 1'b1};
      case (req)
         spmd_pkg::REQ_REGISTER: begin
            if (in_range && !fixed_sig && act <= spmd_pkg::ACT_USER) begin
               res.old_act = model_action[sig[4:0]];
               res.outcome = spmd_pkg::OC_DONE;
               model_action[sig[4:0]] = act;
            end
         end
         spmd_pkg::REQ_MASK: begin
            if (in_range && !fixed_sig) begin
               model_blocked[sig[4:0]] = 1'b1;
               res.outcome = spmd_pkg::OC_DONE;
            end
         end
         spmd_pkg::REQ_UNMASK: begin
            if (in_range) begin
               model_blocked[sig[4:0]] = 1'b0;
               res.outcome = spmd_pkg::OC_DONE;
            end
         end
         spmd_pkg::REQ_SEND: begin
            if (in_range) begin
               if (model_blocked[sig[4:0]]) begin
                  model_pending[sig[4:0]] = 1'b1;
                  res.outcome = spmd_pkg::OC_QUEUED;
               end else begin
                  res.outcome = resolve_outcome(sig, model_action[sig[4:0]]);
               end
            end
         end
         default: ;
      endcase
      if (req == spmd_pkg::REQ_DELIVER) begin
         // scan ascending, one result per deliverable signal
         ready = model_pending & ~model_blocked;
         count = 0;
         for (int i = 1; i < NUM_SIGNALS; i++) begin
            if (ready[i]) begin
               model_pending[i] = 1'b0;
               outcomes_due.push_back('{spmd_pkg::SIG_W'(i),
                                        resolve_outcome(spmd_pkg::SIG_W'(i), model_action[i]),
                                        spmd_pkg::ACT_DEFAULT, 1'b0});
               count++;
            end
         end
         if (count == 0) begin
            outcomes_due.push_back('{'0, spmd_pkg::OC_DONE, spmd_pkg::ACT_DEFAULT, 1'b1});
         end else begin
            outcomes_due[outcomes_due.size()-1].last = 1'b1;
         end
      end else begin
         outcomes_due.push_back(res);
      end
   endtask

   // drive one request transaction, with burst/gap pacing
   task automatic issue_item(input logic [spmd_pkg::REQ_W-1:0] req,
                             input logic [spmd_pkg::SIG_W-1:0] sig,
                             input logic [spmd_pkg::ACT_W-1:0] act, input logic fixed,
                             input sig_result_type fixed_res);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            start             = 1'b0;
            req_type          = spmd_pkg::REQ_W'($urandom);
            req_signal_number = spmd_pkg::SIG_W'($urandom);
            req_new_action    = spmd_pkg::ACT_W'($urandom);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(1, 10);
      end
      @(negedge clock);
      start             = 1'b1;
      req_type          = req;
      req_signal_number = sig;
      req_new_action    = act;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_dispatch(req, sig, act);
      if (fixed) outcomes_due[outcomes_due.size()-1] = fixed_res;
      requests_sent++;
      burst_left--;
   endtask

   task automatic issue_req(input logic [spmd_pkg::REQ_W-1:0] req,
                            input logic [spmd_pkg::SIG_W-1:0] sig,
                            input logic [spmd_pkg::ACT_W-1:0] act);
      issue_item(req, sig, act, 1'b0, '0);
   endtask

   // mostly legal signal numbers, sometimes anything
   function automatic logic [spmd_pkg::SIG_W-1:0] pick_signal();
      if ($urandom_range(0, 6) == 0) return spmd_pkg::SIG_W'($urandom_range(0, 63));
      return spmd_pkg::SIG_W'($urandom_range(1, NUM_SIGNALS - 1));
   endfunction

   task automatic noise_item();
      logic [spmd_pkg::REQ_W-1:0] req;
      logic [spmd_pkg::ACT_W-1:0] act;
      req = ($urandom_range(0, 5) == 0) ?
            spmd_pkg::REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)) :
            spmd_pkg::REQ_W'($urandom_range(spmd_pkg::REQ_REGISTER, spmd_pkg::REQ_DELIVER));
      act = ($urandom_range(0, 5) == 0) ? ACT_INVALID : spmd_pkg::ACT_W'($urandom_range(0, 2));
      issue_req(req, spmd_pkg::SIG_W'($urandom_range(0, 63)), act);
   endtask

   // maybe re-register, block, send, unblock some, then deliver
   task automatic signal_group();
      logic [spmd_pkg::SIG_W-1:0] sigs [6];
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         sigs[i] = pick_signal();
         if ($urandom_range(0, 2) == 0)
            issue_req(spmd_pkg::REQ_REGISTER, sigs[i], spmd_pkg::ACT_W'($urandom_range(0, 2)));
         issue_req(spmd_pkg::REQ_MASK, sigs[i], spmd_pkg::ACT_W'($urandom));
      end
      for (int i = 0; i < n; i++) begin
         issue_req(spmd_pkg::REQ_SEND, sigs[i], spmd_pkg::ACT_W'($urandom));
         if ($urandom_range(0, 4) == 0) noise_item();
      end
      if ($urandom_range(0, 1) == 0)
         issue_req(spmd_pkg::REQ_SEND, pick_signal(), spmd_pkg::ACT_W'($urandom));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) != 0)
            issue_req(spmd_pkg::REQ_UNMASK, sigs[i], spmd_pkg::ACT_W'($urandom));
      end
      issue_req(spmd_pkg::REQ_DELIVER, spmd_pkg::SIG_W'($urandom), spmd_pkg::ACT_W'($urandom));
      if ($urandom_range(0, 3) == 0)
         issue_req(spmd_pkg::REQ_DELIVER, spmd_pkg::SIG_W'($urandom),
                   spmd_pkg::ACT_W'($urandom));
   endtask

   task automatic wait_drained();
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         run_len++;
         if (rsp_last) begin
            if (run_len > longest_run) longest_run = run_len;
            run_len = 0;
         end
         if (outcomes_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual sig %0d outcome %0d",
                     $time, rsp_signal_number_out, rsp_outcome);
            mismatches++;
         end else begin
            head_result = outcomes_due.pop_front();
            check_field("signal", head_result.sig, rsp_signal_number_out);
            check_field("outcome", head_result.outcome, rsp_outcome);
            check_field("old action", head_result.old_act, rsp_old_action);
            check_field("last", head_result.last, rsp_last);
         end
      end
   end

   // stimulus
   initial begin
      logic paused;
      int   random_start;
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = spmd_pkg::REQ_REGISTER;
      req_signal_number = '0;
      req_new_action    = spmd_pkg::ACT_DEFAULT;
      mismatches        = 0;
      requests_sent     = 0;
      results_seen      = 0;
      run_len           = 0;
      longest_run       = 0;
      burst_left        = 0;
      paused            = 1'b0;
      model_pending     = '0;
      model_blocked     = '0;
      for (int i = 0; i < 32; i++) model_action[i] = spmd_pkg::ACT_DEFAULT;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (dispatch_plan[i]) begin
         issue_item(dispatch_plan[i].req, dispatch_plan[i].sig, dispatch_plan[i].act,
                    dispatch_plan[i].fixed,
                    '{dispatch_plan[i].esig, dispatch_plan[i].oc, dispatch_plan[i].old_act,
                      1'b1});
      end

      // random sequences, one full pause halfway
      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) noise_item();
         else signal_group();
         if (!paused && requests_sent - random_start > RANDOM_ITEMS / 2) begin
            @(negedge clock);
            start = 1'b0;
            wait_drained();
            paused = 1'b1;
         end
      end

      // flood: the upper signals all pending, then delivered at once
      for (int s = FLOOD_FIRST; s < NUM_SIGNALS; s++)
         issue_req(spmd_pkg::REQ_MASK, spmd_pkg::SIG_W'(s), spmd_pkg::ACT_DEFAULT);
      for (int s = FLOOD_FIRST; s < NUM_SIGNALS; s++)
         issue_req(spmd_pkg::REQ_SEND, spmd_pkg::SIG_W'(s), spmd_pkg::ACT_DEFAULT);
      for (int s = FLOOD_FIRST; s < NUM_SIGNALS; s++)
         issue_req(spmd_pkg::REQ_UNMASK, spmd_pkg::SIG_W'(s), spmd_pkg::ACT_DEFAULT);
      issue_req(spmd_pkg::REQ_DELIVER, '0, spmd_pkg::ACT_DEFAULT);

      // drain and settle
      @(negedge clock);
      start = 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (outcomes_due.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
         mismatches += outcomes_due.size();
      end
      $display("run covered %0d request transactions and %0d result transactions",
               requests_sent, results_seen);
      $display("longest delivery burst was %0d results", longest_run);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
